### hdl/scba_pkg.sv
// Shared constants, types and helper functions of the size-class block allocator.
package scba_pkg;

  localparam int REGION_LOG2 = 24;
  localparam int NUM_CLASSES = 6;
  localparam int MIN_LOG     = 16;
  localparam int PTR_W       = REGION_LOG2 - MIN_LOG;
  localparam int CNT_W       = PTR_W + 1;
  localparam int CLASS_W     = 3;
  localparam int ADDR_W      = 48;
  localparam int REQ_W       = 40;
  localparam int BYTES_W     = 41;
  localparam int USED_W      = 9;
  localparam int RAM_AW      = CLASS_W + PTR_W;
  localparam int RAM_DEPTH   = 1 << RAM_AW;

  localparam logic [CLASS_W-1:0] NO_CLASS = CLASS_W'(NUM_CLASSES);
  localparam logic [BYTES_W-1:0] GRAN_MASK = BYTES_W'(64'hffff);

  // action codes
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FALLBACK = 2'd1;
  localparam logic [1:0] ST_FOREIGN  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // Number of blocks a class region holds.
  function automatic cnt_t class_total(input int c);
    if (MIN_LOG + c > REGION_LOG2) begin
      return '0;
    end
    return cnt_t'(1) << (REGION_LOG2 - MIN_LOG - c);
  endfunction

  // Block size of a class in bytes.
  function automatic logic [BYTES_W-1:0] class_bytes(input int c);
    return BYTES_W'(1) << (MIN_LOG + c);
  endfunction

endpackage

### hdl/scba_ram.sv
// Generic simple dual-port RAM with registered read.
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/scba_ctrl.sv
// Sequencer: accept, evaluate and finish one request at a time.
module scba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  scba_pkg::stat_t stat,
  output scba_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  // Decode commands from the current state
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_eval_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |=> state == S_DONE)
    else $error("evaluation not followed by finish state");
  a_load_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.eval && !in_ready)
    else $error("accepted word not evaluated next cycle");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> stat.out_free)
    else $error("result loaded into a full output register");

endmodule

### hdl/scba_datapath.sv
// Free counts, stack memory, classification and result register.
module scba_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  scba_pkg::cmd_t                 cmd,
  output scba_pkg::stat_t                stat,
  input  logic                           cfg_we,
  input  logic [scba_pkg::ADDR_W-1:0]    cfg_data,
  input  logic [1:0]                     in_action,
  input  logic [scba_pkg::REQ_W-1:0]     in_req,
  input  logic [scba_pkg::ADDR_W-1:0]    in_addr,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [scba_pkg::ADDR_W-1:0]    out_grant,
  output logic [scba_pkg::BYTES_W-1:0]   out_bytes,
  output logic [scba_pkg::CLASS_W-1:0]   out_class,
  output logic [scba_pkg::USED_W-1:0]    out_used
);

  localparam int RW = scba_pkg::ADDR_W - scba_pkg::REGION_LOG2;

  logic [scba_pkg::ADDR_W-1:0]  base;
  logic [1:0]                   act_q;
  logic [scba_pkg::REQ_W-1:0]   req_q;
  logic [scba_pkg::ADDR_W-1:0]  addr_q;
  scba_pkg::cnt_t               cnt [scba_pkg::NUM_CLASSES];
  scba_pkg::cnt_t               low [scba_pkg::NUM_CLASSES];

  logic [1:0]                   r_status;
  logic [scba_pkg::CLASS_W-1:0] r_class;
  logic [scba_pkg::BYTES_W-1:0] r_bytes;
  logic [scba_pkg::USED_W-1:0]  r_used;
  logic                         r_grant;
  logic                         r_use_ram;
  logic [scba_pkg::PTR_W-1:0]   r_const_idx;

  logic [scba_pkg::ADDR_W-1:0]  off;
  logic [RW-1:0]                region;
  logic                         in_pool;
  logic                         hit_any;
  logic [scba_pkg::CLASS_W-1:0] pick, sel;
  scba_pkg::cnt_t               cnt_s, low_s, tot_s, cnt_m1;
  logic [scba_pkg::BYTES_W-1:0] rounded;
  logic [scba_pkg::REGION_LOG2-1:0] push_full;
  logic [scba_pkg::PTR_W-1:0]   push_idx;
  logic                         do_pop, do_push;
  logic [1:0]                   e_status;
  logic [scba_pkg::CLASS_W-1:0] e_class;
  logic [scba_pkg::BYTES_W-1:0] e_bytes;
  scba_pkg::cnt_t               e_used;
  logic [scba_pkg::PTR_W-1:0]   rdata, idx_f;
  logic [scba_pkg::ADDR_W-1:0]  grant_f;

  assign stat.out_free = !out_valid || out_ready;

  // Classify, pick a class and decide the stack operation
  always_comb begin
    off     = addr_q - base;
    region  = off[scba_pkg::ADDR_W-1:scba_pkg::REGION_LOG2];
    in_pool = (addr_q >= base) && (region < RW'(scba_pkg::NUM_CLASSES));
    hit_any = 1'b0;
    pick    = '0;
    for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
      if ({1'b0, req_q} <= scba_pkg::class_bytes(c) && cnt[c] != '0) begin
        hit_any = 1'b1;
        pick    = scba_pkg::CLASS_W'(c);
      end
    end
    if (act_q == scba_pkg::ACT_ALLOC) begin
      sel = pick;
    end else if (in_pool) begin
      sel = region[scba_pkg::CLASS_W-1:0];
    end else begin
      sel = '0;
    end
    cnt_s   = cnt[sel];
    low_s   = low[sel];
    tot_s   = scba_pkg::class_total(int'(sel));
    cnt_m1  = cnt_s - scba_pkg::cnt_t'(1);
    rounded = ({1'b0, req_q} + scba_pkg::GRAN_MASK) & ~scba_pkg::GRAN_MASK;
    push_full = off[scba_pkg::REGION_LOG2-1:0] >> (scba_pkg::MIN_LOG + int'(sel));
    if (scba_pkg::CNT_W'(push_full) >= tot_s
        || push_full[scba_pkg::REGION_LOG2-1:scba_pkg::PTR_W] != '0) begin
      push_idx = scba_pkg::PTR_W'(tot_s - scba_pkg::cnt_t'(1));
    end else begin
      push_idx = push_full[scba_pkg::PTR_W-1:0];
    end

    e_status = scba_pkg::ST_FOREIGN;
    e_class  = scba_pkg::NO_CLASS;
    e_bytes  = '0;
    e_used   = '0;
    do_pop   = 1'b0;
    do_push  = 1'b0;
    case (act_q)
      scba_pkg::ACT_ALLOC: begin
        if (hit_any) begin
          e_status = scba_pkg::ST_OK;
          e_class  = sel;
          e_bytes  = scba_pkg::class_bytes(int'(sel));
          e_used   = tot_s - cnt_m1;
          do_pop   = 1'b1;
        end else begin
          e_status = scba_pkg::ST_FALLBACK;
          e_bytes  = rounded;
        end
      end
      scba_pkg::ACT_FREE: begin
        if (in_pool) begin
          e_class = sel;
          e_bytes = scba_pkg::class_bytes(int'(sel));
          if (cnt_s >= tot_s) begin
            e_status = scba_pkg::ST_OVERFLOW;
            e_used   = tot_s - cnt_s;
          end else begin
            e_status = scba_pkg::ST_OK;
            e_used   = tot_s - cnt_s - scba_pkg::cnt_t'(1);
            do_push  = 1'b1;
          end
        end
      end
      scba_pkg::ACT_QUERY: begin
        if (in_pool) begin
          e_status = scba_pkg::ST_OK;
          e_class  = sel;
          e_bytes  = scba_pkg::class_bytes(int'(sel));
          e_used   = tot_s - cnt_s;
        end else begin
          e_bytes = rounded;
        end
      end
      default: begin
        e_status = scba_pkg::ST_FOREIGN;
      end
    endcase
  end

  // Stack storage for all classes, addressed by class and depth
  scba_ram #(
    .WIDTH(scba_pkg::PTR_W),
    .DEPTH(scba_pkg::RAM_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.eval && do_push),
    .waddr({sel, cnt_s[scba_pkg::PTR_W-1:0]}),
    .wdata(push_idx),
    .re   (cmd.eval && do_pop),
    .raddr({sel, cnt_m1[scba_pkg::PTR_W-1:0]}),
    .rdata(rdata)
  );

  // Hold base address and update per-class counters
  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
      for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
        cnt[c] <= scba_pkg::class_total(c);
        low[c] <= scba_pkg::class_total(c);
      end
    end else begin
      if (cfg_we) begin
        base <= cfg_data;
      end
      if (cmd.eval && do_pop) begin
        cnt[sel] <= cnt_m1;
        if (cnt_m1 < low_s) begin
          low[sel] <= cnt_m1;
        end
      end
      if (cmd.eval && do_push) begin
        cnt[sel] <= cnt_s + scba_pkg::cnt_t'(1);
      end
    end
  end

  // Capture the request and the evaluation result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= in_action;
      req_q  <= in_req;
      addr_q <= in_addr;
    end
    if (cmd.eval) begin
      r_status    <= e_status;
      r_class     <= e_class;
      r_bytes     <= e_bytes;
      r_used      <= e_used[scba_pkg::USED_W-1:0];
      r_grant     <= do_pop;
      // entries below the lowest depth ever reached were never written; their initial value comes from the count
      r_use_ram   <= cnt_m1 >= low_s;
      r_const_idx <= scba_pkg::PTR_W'(tot_s - cnt_s);
    end
  end

  // Form the granted address
  always_comb begin
    idx_f   = r_use_ram ? rdata : r_const_idx;
    grant_f = base
            + (scba_pkg::ADDR_W'(r_class) << scba_pkg::REGION_LOG2)
            + (scba_pkg::ADDR_W'(idx_f) << (scba_pkg::MIN_LOG + int'(r_class)));
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status <= r_status;
      out_grant  <= r_grant ? grant_f : '0;
      out_bytes  <= r_bytes;
      out_class  <= r_class;
      out_used   <= r_used;
    end
  end

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && do_pop |=> cnt[$past(sel)] == $past(cnt_s) - scba_pkg::cnt_t'(1))
    else $error("pop did not decrement free count");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.eval && do_push |-> cnt_s < tot_s)
    else $error("push onto full stack");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_grant))
    else $error("stalled result changed");

endmodule

### hdl/size_class_block_allocator.sv
// Top level of the size-class block allocator.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+--------------------------------
//  request  | s_tvalid s_tready s_tdata s_tuser | action, request_bytes, address
//  result   | m_tvalid m_tready m_tdata m_tuser | status, grant, bytes, class, used
//  config   | cfg_valid cfg_ready cfg_data    | pool_base
//
// Each word passes through three steps: accept, evaluate (class pick, count update and
// stack memory access), finish (registered stack read, address add).
// A stalled result holds in the output register; the next word is accepted
// meanwhile and waits in the finish state until the register frees.
// Reset is immediate: free counts load their full values, no clearing pass.
// Config writes are always ready.
module size_class_block_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // request_bytes[39:0], block_address[87:40]
  input  logic [1:0]   s_tuser,   // action[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // granted_address[47:0], block_bytes[88:48],
                                  // size_class[91:89], used_blocks[100:92], zero
  output logic [1:0]   m_tuser,   // status[1:0]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [47:0]  cfg_data   // pool_base[47:0]
);

  scba_pkg::cmd_t  cmd;
  scba_pkg::stat_t stat;
  logic [scba_pkg::ADDR_W-1:0]  grant;
  logic [scba_pkg::BYTES_W-1:0] bytes;
  logic [scba_pkg::CLASS_W-1:0] cls;
  logic [scba_pkg::USED_W-1:0]  used;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, used, cls, bytes, grant};

  scba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  scba_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_action (s_tuser),
    .in_req    (s_tdata[39:0]),
    .in_addr   (s_tdata[87:40]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_status(m_tuser),
    .out_grant (grant),
    .out_bytes (bytes),
    .out_class (cls),
    .out_used  (used)
  );

endmodule
